@@ src/sle_pkg.sv @@
// Shared types and constants for the sorted list engine.
`timescale 1ns / 1ps

package sle_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int DATA_W       = 32;
    localparam int ACTION_W     = 2;
    localparam int STATUS_W     = 2;
    localparam int POS_W        = 4;
    localparam int COUNT_W      = 5;

    typedef enum logic [ACTION_W-1:0] {
        ACT_INSERT = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_SEARCH = 2'd2
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    // Broadcast to every cell in the chain.
    typedef struct packed {
        logic                     ins;
        logic                     rem;
        logic signed [DATA_W-1:0] value;
    } sle_cmd_t;

    // Per-cell compare results.
    typedef struct packed {
        logic less;
        logic eq;
        logic bnd;
    } sle_flags_t;

endpackage

@@ src/sle_if.sv @@
// Valid/ready channel interfaces for request and response words.
`timescale 1ns / 1ps

interface sle_req_if;
    import sle_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [ACTION_W-1:0]       action;
    logic signed [DATA_W-1:0]  value;

    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);
endinterface

interface sle_rsp_if;
    import sle_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic [POS_W-1:0]     position;
    logic [COUNT_W-1:0]   entry_count;

    modport source (output valid, output status, output position, output entry_count,
                    input ready);
    modport sink   (input valid, input status, input position, input entry_count,
                    output ready);
endinterface

@@ src/sle_cell.sv @@
// One slot of the sorted chain: compare against the broadcast value and shift.
`timescale 1ns / 1ps

module sle_cell #(
    parameter int INDEX = 0,
    parameter int CNT_W = 5
) (
    input  logic                             clk,
    input  sle_pkg::sle_cmd_t                cmd,
    input  logic [CNT_W-1:0]                 fill,
    input  logic                             left_less,
    input  logic signed [sle_pkg::DATA_W-1:0] left_entry,
    input  logic signed [sle_pkg::DATA_W-1:0] right_entry,
    output logic signed [sle_pkg::DATA_W-1:0] entry,
    output sle_pkg::sle_flags_t              flags
);
    import sle_pkg::*;

    logic signed [DATA_W-1:0] entry_reg;
    logic signed [DATA_W-1:0] entry_next;
    logic                     occupied;

    assign occupied   = fill > CNT_W'(INDEX);
    assign flags.less = occupied && (entry_reg < cmd.value);
    assign flags.eq   = occupied && (entry_reg == cmd.value);
    // first slot not less than the value
    assign flags.bnd  = left_less && !flags.less;
    assign entry      = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.ins)
        begin
            if (!left_less)
                entry_next = left_entry;
            else if (flags.bnd)
                entry_next = cmd.value;
        end
        else if (cmd.rem)
        begin
            if (!flags.less)
                entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

@@ src/sorted_list_engine.sv @@
// Sorted list engine: a chain of compare-and-shift cells holding an ascending table.
// Throughput: one request per cycle unless a full response register is held by rsp.ready low;
// every cell compares and shifts in the same cycle.
// A request is taken while the response register is empty or being drained.
// Reset (rst_n, async, active low) empties the table and the response register.
`timescale 1ns / 1ps

module sorted_list_engine #(
    parameter int CAPACITY = sle_pkg::CAPACITY_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    sle_req_if.sink     req,
    sle_rsp_if.source   rsp
);
    import sle_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0]          fill_reg;
    logic [CNT_W-1:0]          fill_next;
    logic                      rsp_valid_reg;
    logic [STATUS_W-1:0]       status_reg;
    logic [STATUS_W-1:0]       status_next;
    logic [POS_W-1:0]          position_reg;
    logic [POS_W-1:0]          position_next;
    logic [COUNT_W-1:0]        count_reg;

    sle_cmd_t                  cmd;
    sle_flags_t                flags [CAPACITY];
    logic signed [DATA_W-1:0]  entry [CAPACITY];
    logic [CAPACITY:0]         less_chain;

    logic                      accept;
    logic                      full;
    logic                      hit;
    logic [IDX_W-1:0]          pos;
    logic [IDX_W+POS_W-1:0]    pos_ext;
    logic [CNT_W+COUNT_W-1:0]  cnt_ext;

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign full      = fill_reg == CNT_W'(CAPACITY);

    // slot zero always sees a "less" neighbor on its left
    assign less_chain[0] = 1'b1;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            logic signed [DATA_W-1:0] left_e;
            logic signed [DATA_W-1:0] right_e;

            if (g == 0)
            begin : g_first
                assign left_e = req.value;
            end
            else
            begin : g_mid
                assign left_e = entry[g-1];
            end

            if (g == CAPACITY - 1)
            begin : g_last
                assign right_e = entry[g];
            end
            else
            begin : g_inner
                assign right_e = entry[g+1];
            end

            sle_cell #(
                .INDEX (g),
                .CNT_W (CNT_W)
            ) u_cell (
                .clk         (clk),
                .cmd         (cmd),
                .fill        (fill_reg),
                .left_less   (less_chain[g]),
                .left_entry  (left_e),
                .right_entry (right_e),
                .entry       (entry[g]),
                .flags       (flags[g])
            );

            assign less_chain[g+1] = flags[g].less;
        end
    endgenerate

    // boundary is one-hot, so OR the indexes together
    always_comb
    begin
        pos = '0;
        hit = 1'b0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (flags[i].bnd)
            begin
                pos = pos | IDX_W'(i);
                hit = hit | flags[i].eq;
            end
        end
    end

    assign pos_ext = {{POS_W{1'b0}}, pos};

    always_comb
    begin
        cmd.value     = req.value;
        cmd.ins       = 1'b0;
        cmd.rem       = 1'b0;
        fill_next     = fill_reg;
        status_next   = ST_MISS;
        position_next = '0;
        case (req.action)
            ACT_INSERT:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    cmd.ins       = accept;
                    fill_next     = fill_reg + CNT_W'(1);
                    status_next   = ST_DONE;
                    position_next = pos_ext[POS_W-1:0];
                end
            end
            ACT_REMOVE:
            begin
                if (hit)
                begin
                    cmd.rem       = accept;
                    fill_next     = fill_reg - CNT_W'(1);
                    status_next   = ST_DONE;
                    position_next = pos_ext[POS_W-1:0];
                end
            end
            ACT_SEARCH:
            begin
                if (hit)
                begin
                    status_next   = ST_DONE;
                    position_next = pos_ext[POS_W-1:0];
                end
            end
            default:
            begin
                status_next = ST_MISS;
            end
        endcase
    end

    assign cnt_ext = {{COUNT_W{1'b0}}, fill_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                fill_reg      <= fill_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg   <= status_next;
            position_reg <= position_next;
            count_reg    <= cnt_ext[COUNT_W-1:0];
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.position    = position_reg;
    assign rsp.entry_count = count_reg;

endmodule
